FILE: rtl/bc128_pkg.sv
// Shared types, constants and round functions of the 128-bit block cipher core.
package bc128_pkg;

	// Field and register widths
	localparam int unsigned BlockW   = 128;
	localparam int unsigned HalfW    = 64;
	localparam int unsigned RowW     = 32;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned KeyAddrW = 4;
	localparam int unsigned StepW    = 4;

	// Round key store and schedule
	localparam int unsigned KeyRows     = 15;
	localparam int unsigned KeySteps    = 14;
	localparam int unsigned NumRoundsDef = 14;

	// Register indexes of the write port
	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_KEY_HIGH = cfg_idx_t'(0);
	localparam cfg_idx_t REG_KEY_LOW  = cfg_idx_t'(1);

	// Circulant matrix columns
	localparam logic [RowW-1:0] MAT_ROW0  = 32'ha3861085;
	localparam logic [RowW-1:0] MAT_ROW1  = 32'h63417021;
	localparam logic [RowW-1:0] MAT_ROW2  = 32'h692cf280;
	localparam logic [RowW-1:0] MAT_ROW3  = 32'h48a54813;
	localparam logic [RowW-1:0] MAT_KEY   = 32'hb881b9ca;
	localparam logic [RowW-1:0] IMAT_ROW0 = 32'h2037a121;
	localparam logic [RowW-1:0] IMAT_ROW1 = 32'h108ff2a0;
	localparam logic [RowW-1:0] IMAT_ROW2 = 32'h9054d8c0;
	localparam logic [RowW-1:0] IMAT_ROW3 = 32'h3354b117;

	// Key schedule constants
	localparam logic [RowW-1:0] KC0 = 32'h00000080;
	localparam logic [RowW-1:0] KC1 = 32'h00006a00;
	localparam logic [RowW-1:0] KC2 = 32'h003f0000;
	localparam logic [RowW-1:0] KC3 = 32'h24000000;

	// Commands from controller to datapath
	typedef struct packed {
		logic                load;
		logic                ks_load;
		logic                ks_write;
		logic [KeyAddrW-1:0] ks_idx;
		logic                rd_en;
		logic [StepW-1:0]    rd_step;
		logic                step_en;
		logic [StepW-1:0]    step;
		logic                out_load;
		logic                out_from_step;
	} bc128_cmd_t;

	// Rotate right by a constant amount
	function automatic logic [RowW-1:0] rotr(input logic [RowW-1:0] x, input int unsigned n);
		logic [2*RowW-1:0] d;
		d = {x, x} >> n;
		return d[RowW-1:0];
	endfunction

	// Circulant GF(2) matrix with first column col, times v
	function automatic logic [RowW-1:0] circ_mul(input logic [RowW-1:0] col,
		input logic [RowW-1:0] v);
		logic [RowW-1:0] acc;
		acc = '0;
		for (int b = 0; b < RowW; b++) begin
			if (v[b])
				acc ^= rotr(col, (RowW - 1) - b);
		end
		return acc;
	endfunction

	// Bitsliced S-box across the four rows
	function automatic logic [BlockW-1:0] sbox(input logic [BlockW-1:0] x);
		logic [RowW-1:0] a0, a1, a2, a3;
		{a0, a1, a2, a3} = x;
		a0 ^= a3;
		a3 ^= a0 & a1;
		a0 ^= a1 & a2;
		a1 ^= a2 & a3;
		a2 ^= a0 & a3;
		a2 ^= a1;
		a1 ^= a0;
		a3 = ~a3;
		return {a0, a1, a3, a2};
	endfunction

	// Inverse S-box
	function automatic logic [BlockW-1:0] inv_sbox(input logic [BlockW-1:0] x);
		logic [RowW-1:0] a0, a1, a2, a3;
		{a0, a1, a3, a2} = x;
		a3 = ~a3;
		a1 ^= a0;
		a2 ^= a1;
		a2 ^= a3 & a0;
		a1 ^= a2 & a3;
		a0 ^= a1 & a2;
		a3 ^= a0 & a1;
		a0 ^= a3;
		return {a0, a1, a2, a3};
	endfunction

	function automatic logic [BlockW-1:0] mix(input logic [BlockW-1:0] x);
		return {circ_mul(MAT_ROW0, x[127:96]), circ_mul(MAT_ROW1, x[95:64]),
			circ_mul(MAT_ROW2, x[63:32]), circ_mul(MAT_ROW3, x[31:0])};
	endfunction

	function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] x);
		return {circ_mul(IMAT_ROW0, x[127:96]), circ_mul(IMAT_ROW1, x[95:64]),
			circ_mul(IMAT_ROW2, x[63:32]), circ_mul(IMAT_ROW3, x[31:0])};
	endfunction

	// One key schedule step from round key p, step number s
	function automatic logic [BlockW-1:0] ks_next(input logic [BlockW-1:0] p,
		input logic [KeyAddrW-1:0] s);
		logic [RowW-1:0] t, n0, n1, n2, n3;
		t  = p[127:96] ^ p[95:64] ^ p[63:32] ^ p[31:0];
		n0 = circ_mul(MAT_KEY, p[127:96] ^ t) ^ KC0 ^ RowW'(s);
		n1 = rotr(p[95:64] ^ t, 8) ^ KC1;
		n2 = rotr(p[63:32] ^ t, 15) ^ KC2;
		n3 = rotr(p[31:0] ^ t, 18) ^ KC3;
		return {n0, n1, n2, n3};
	endfunction

endpackage

FILE: rtl/bc128_in_if.sv
// Input channel: block request with direction bit.
interface bc128_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        decrypt;

	modport source (output valid, output block_high, output block_low, output decrypt,
		input ready);
	modport sink (input valid, input block_high, input block_low, input decrypt,
		output ready);
endinterface

FILE: rtl/bc128_out_if.sv
// Output channel: transformed block request.
interface bc128_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	modport source (output valid, output result_high, output result_low, input ready);
	modport sink (input valid, input result_high, input result_low, output ready);
endinterface

FILE: rtl/bc128_ctrl.sv
// Controller: key schedule sequencing, round counting and output hand-off.
module bc128_ctrl #(
	parameter int unsigned NUM_ROUNDS = bc128_pkg::NumRoundsDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blk_valid,
	output logic                  blk_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	input  logic                  cfg_we,
	input  bc128_pkg::cfg_idx_t   cfg_idx,
	output bc128_pkg::bc128_cmd_t cmd
);
	import bc128_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_KEY, ST_PREP, ST_RUN, ST_DONE} state_t;

	localparam logic [StepW-1:0]    LastStep = StepW'(NUM_ROUNDS);
	localparam logic [KeyAddrW-1:0] KsLast   = KeyAddrW'(KeySteps);

	state_t              state_q, state_d;
	logic [StepW-1:0]    step_q;
	logic [KeyAddrW-1:0] ks_cnt_q;
	logic                keys_ready_q;
	logic                res_valid_q;
	logic                accept;
	logic                out_free;
	logic                key_write;

	assign blk_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign accept    = blk_valid && blk_ready;
	assign out_free  = !res_valid_q || res_ready;
	assign key_write = cfg_we && (cfg_idx == REG_KEY_HIGH || cfg_idx == REG_KEY_LOW);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.ks_idx  = ks_cnt_q;
		cmd.step    = step_q;
		cmd.rd_step = step_q + StepW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (keys_ready_q) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_step = '0;
						state_d     = ST_RUN;
					end else begin
						cmd.ks_load = 1'b1;
						state_d     = ST_KEY;
					end
				end
			end
			ST_KEY: begin
				cmd.ks_write = 1'b1;
				if (ks_cnt_q == KsLast)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_step = '0;
				state_d     = ST_RUN;
			end
			ST_RUN: begin
				cmd.step_en = 1'b1;
				cmd.rd_en   = (step_q != LastStep);
				if (step_q == LastStep) begin
					if (out_free) begin
						cmd.out_load      = 1'b1;
						cmd.out_from_step = 1'b1;
						state_d           = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, counters and registered status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			ks_cnt_q     <= '0;
			keys_ready_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				ks_cnt_q <= '0;
			else if (state_q == ST_KEY)
				ks_cnt_q <= ks_cnt_q + KeyAddrW'(1);
			if (state_q == ST_RUN)
				step_q <= step_q + StepW'(1);
			else
				step_q <= '0;
			if (key_write)
				keys_ready_q <= 1'b0;
			else if (state_q == ST_KEY && ks_cnt_q == KsLast)
				keys_ready_q <= 1'b1;
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// Round keys are in place whenever a round runs
	a_keys_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_PREP) |-> keys_ready_q)
		else $error("round started without expanded keys");

	// The round counter never passes the final key add
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= LastStep))
		else $error("round counter out of range");

	// A finished block with a free output register is presented next cycle
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == LastStep && out_free) |=> res_valid_q)
		else $error("finished block not presented");

	// Expanded keys are only dropped by a key register write
	a_keys_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(keys_ready_q) |-> $past(key_write))
		else $error("round keys invalidated without key write");

endmodule

FILE: rtl/bc128_dpath.sv
// Datapath: key registers, round key store, schedule step, round unit, output register.
module bc128_dpath #(
	parameter int unsigned NUM_ROUNDS = bc128_pkg::NumRoundsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bc128_pkg::bc128_cmd_t           cmd,
	input  logic                            cfg_we,
	input  bc128_pkg::cfg_idx_t             cfg_idx,
	input  logic [bc128_pkg::HalfW-1:0]     cfg_wdata,
	input  logic [bc128_pkg::HalfW-1:0]     block_high,
	input  logic [bc128_pkg::HalfW-1:0]     block_low,
	input  logic                            decrypt,
	output logic [bc128_pkg::HalfW-1:0]     result_high,
	output logic [bc128_pkg::HalfW-1:0]     result_low
);
	import bc128_pkg::*;

	localparam logic [KeyAddrW-1:0] LastKey  = KeyAddrW'(NUM_ROUNDS);
	localparam logic [StepW-1:0]    LastStep = StepW'(NUM_ROUNDS);

	logic [HalfW-1:0]    key_high_q, key_low_q;
	logic [BlockW-1:0]   rk_mem [KeyRows];
	logic [BlockW-1:0]   rk_q;
	logic [BlockW-1:0]   ks_q;
	logic [BlockW-1:0]   x_q, x_next, x_key;
	logic [BlockW-1:0]   out_q;
	logic                dec_q;
	logic                rd_dir;
	logic [KeyAddrW-1:0] rd_addr;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_HIGH: key_high_q <= cfg_wdata;
				REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Round key read address: forward order to encrypt, backward to decrypt
	assign rd_dir  = cmd.load ? decrypt : dec_q;
	assign rd_addr = rd_dir ? (LastKey - KeyAddrW'(cmd.rd_step)) : KeyAddrW'(cmd.rd_step);

	// Round key store with one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.ks_write)
			rk_mem[cmd.ks_idx] <= ks_q;
		if (cmd.rd_en)
			rk_q <= rk_mem[rd_addr];
	end

	// Key schedule state
	always_ff @(posedge clk) begin
		if (cmd.ks_load)
			ks_q <= {key_high_q, key_low_q};
		else if (cmd.ks_write)
			ks_q <= ks_next(ks_q, cmd.ks_idx);
	end

	// Round unit
	assign x_key = x_q ^ rk_q;
	always_comb begin
		if (!dec_q)
			x_next = (cmd.step == LastStep) ? x_key : mix(sbox(x_key));
		else
			x_next = (cmd.step == '0) ? x_key : (inv_sbox(inv_mix(x_q)) ^ rk_q);
	end

	// Block state and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= {block_high, block_low};
			dec_q <= decrypt;
		end else if (cmd.step_en) begin
			x_q <= x_next;
		end
		if (cmd.out_load)
			out_q <= cmd.out_from_step ? x_next : x_q;
	end

	assign result_high = out_q[BlockW-1:HalfW];
	assign result_low  = out_q[HalfW-1:0];

endmodule

FILE: rtl/block_cipher_128bit_enc_dec_core.sv
// Top level: 128-bit block cipher, one round per cycle, encrypt or decrypt.
// With keys expanded, an accepted block goes straight to its rounds, then its result is presented.
// A new block is accepted only once the previous result has been loaded into the output register.
// After reset or a key write the first block waits for 15 schedule steps and then one key read.
// Reset (arst_n, asynchronous) clears control, key registers and the key-ready flag;
// the round key store itself is not cleared and is always rewritten before use.
module block_cipher_128bit_enc_dec_core #(
	parameter int unsigned NUM_ROUNDS = bc128_pkg::NumRoundsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bc128_in_if.sink                     blocks,
	bc128_out_if.source                  results,
	input  logic                         cfg_we,
	input  bc128_pkg::cfg_idx_t          cfg_idx,
	input  logic [bc128_pkg::HalfW-1:0]  cfg_wdata
);
	import bc128_pkg::*;

	bc128_cmd_t cmd;

	// Sequencing
	bc128_ctrl #(.NUM_ROUNDS(NUM_ROUNDS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blocks.valid),
		.blk_ready (blocks.ready),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cmd       (cmd)
	);

	// Cipher datapath
	bc128_dpath #(.NUM_ROUNDS(NUM_ROUNDS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.block_high  (blocks.block_high),
		.block_low   (blocks.block_low),
		.decrypt     (blocks.decrypt),
		.result_high (results.result_high),
		.result_low  (results.result_low)
	);

endmodule
